### sv/oled_text_glyph_stream_macros.svh
// ----------------------------------------------------------------------------
// OLED text glyph stream assertion macros
// Shared concurrent assertion forms used across the glyph stream RTL.
// ----------------------------------------------------------------------------
`ifndef OLED_TEXT_GLYPH_STREAM_MACROS_SVH
`define OLED_TEXT_GLYPH_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OTGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/otgs_pkg.sv
// ----------------------------------------------------------------------------
// OLED text glyph stream package
// Types, constants, the 5x7 glyph ROM and the beat generator.
// ----------------------------------------------------------------------------
package otgs_pkg;

  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_HI_BASE   = 8'h10;
  localparam logic [7:0] COL_STEP      = 8'd6;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9  = 8'h39;
  localparam logic [5:0] DIGIT_GLYPH_BASE = 6'd27;
  localparam logic [5:0] BLANK_GLYPH      = 6'd0;
  localparam logic [3:0] COL_OFFSET_RESET = 4'd2;

  // Byte positions within one character's stream.
  localparam logic [3:0] IDX_PAGE_CTL    = 4'd0;
  localparam logic [3:0] IDX_PAGE_CMD    = 4'd1;
  localparam logic [3:0] IDX_LO_CTL      = 4'd2;
  localparam logic [3:0] IDX_LO_CMD      = 4'd3;
  localparam logic [3:0] IDX_HI_CTL      = 4'd4;
  localparam logic [3:0] IDX_HI_CMD      = 4'd5;
  localparam logic [3:0] IDX_DATA_CTL    = 4'd6;
  localparam logic [3:0] IDX_GLYPH_FIRST = 4'd7;
  localparam logic [3:0] IDX_GLYPH_LAST  = 4'd11;
  localparam logic [3:0] IDX_SPACE_LAST  = 4'd12;
  localparam logic [3:0] IDX_PAD_CTL     = 4'd12;
  localparam logic [3:0] IDX_PAD_BYTE    = 4'd13;

  // Queue depth must be a power of two.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       is_space;
    logic [2:0] page;
    logic [7:0] col;
    logic [5:0] glyph_idx;
  } desc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       tx_start;
    logic       tx_end;
    logic       last;
  } beat_t;

  function automatic logic [39:0] glyph_row(input logic [5:0] idx);
    logic [39:0] row;
    case (idx)
      6'd1:  row = 40'h7E1111117E;
      6'd2:  row = 40'h7F49494936;
      6'd3:  row = 40'h3E41414122;
      6'd4:  row = 40'h7F4141221C;
      6'd5:  row = 40'h7F49494941;
      6'd6:  row = 40'h7F09090901;
      6'd7:  row = 40'h3E4149497A;
      6'd8:  row = 40'h7F0808087F;
      6'd9:  row = 40'h00417F4100;
      6'd10: row = 40'h2040413F01;
      6'd11: row = 40'h7F08142241;
      6'd12: row = 40'h7F40404040;
      6'd13: row = 40'h7F0204027F;
      6'd14: row = 40'h7F0408107F;
      6'd15: row = 40'h3E4141413E;
      6'd16: row = 40'h7F09090906;
      6'd17: row = 40'h3E4151215E;
      6'd18: row = 40'h7F09192946;
      6'd19: row = 40'h4649494931;
      6'd20: row = 40'h01017F0101;
      6'd21: row = 40'h3F4040403F;
      6'd22: row = 40'h1F2040201F;
      6'd23: row = 40'h7F2018207F;
      6'd24: row = 40'h6314081463;
      6'd25: row = 40'h0304780403;
      6'd26: row = 40'h6151494543;
      6'd27: row = 40'h3E5149453E;
      6'd28: row = 40'h00427F4000;
      6'd29: row = 40'h4261514946;
      6'd30: row = 40'h2141454B31;
      6'd31: row = 40'h1814127F10;
      6'd32: row = 40'h2745454539;
      6'd33: row = 40'h3C4A494930;
      6'd34: row = 40'h0171090503;
      6'd35: row = 40'h3649494936;
      6'd36: row = 40'h064949291E;
      default: row = 40'h0000000000;
    endcase
    return row;
  endfunction

  function automatic beat_t gen_beat(input desc_t d, input logic [3:0] k);
    beat_t       b;
    logic [39:0] row;
    logic [2:0]  gi;
    row = glyph_row(d.glyph_idx);
    gi  = 3'(k - IDX_GLYPH_FIRST);
    b   = '0;
    unique case (k) inside
      IDX_PAGE_CTL, IDX_LO_CTL, IDX_HI_CTL: begin
        b.data     = CTRL_CMD;
        b.tx_start = 1'b1;
      end
      IDX_PAGE_CMD: begin
        b.data   = PAGE_CMD_BASE | {5'd0, d.page};
        b.tx_end = 1'b1;
      end
      IDX_LO_CMD: begin
        b.data   = {4'd0, d.col[3:0]};
        b.tx_end = 1'b1;
      end
      IDX_HI_CMD: begin
        b.data   = COL_HI_BASE + {4'd0, d.col[7:4]};
        b.tx_end = 1'b1;
      end
      IDX_DATA_CTL: begin
        b.data     = CTRL_DATA;
        b.tx_start = 1'b1;
      end
      [IDX_GLYPH_FIRST:IDX_GLYPH_LAST]: begin
        b.data   = d.is_space ? 8'd0 : row[39 - 8 * gi -: 8];
        b.tx_end = !d.is_space && (k == IDX_GLYPH_LAST);
      end
      IDX_PAD_CTL: begin
        b.data     = d.is_space ? 8'd0 : CTRL_DATA;
        b.tx_start = !d.is_space;
        b.tx_end   = d.is_space;
        b.last     = d.is_space;
      end
      IDX_PAD_BYTE: begin
        b.data   = 8'd0;
        b.tx_end = 1'b1;
        b.last   = 1'b1;
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

### sv/oled_text_glyph_stream.sv
// A character's first beat goes via the descriptor queue and the output register.
// One beat per cycle leaves the output register unless out_ready holds it, so a
// space is 13 beats and any other character 14 beats, set by the byte sequencer.
// A two-entry descriptor queue lets the next characters be taken meanwhile.
// Reset (synchronous, active low): running column 0, column offset 2, queue
// and output register empty.
// ----------------------------------------------------------------------------
// OLED text glyph stream
// Turns text characters into the paged OLED command and data byte stream.
// ----------------------------------------------------------------------------
module oled_text_glyph_stream
  import otgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_page_number,
  input  logic [7:0] in_start_column,
  input  logic       in_first_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_wire_byte,
  output logic       out_transaction_start,
  output logic       out_transaction_end,
  output logic       out_last_of_item,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic  q_full;
  logic  q_push;
  desc_t q_desc;
  logic  q_pop;
  logic  q_head_valid;
  desc_t q_head_desc;

  otgs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_page_number   (in_page_number),
    .in_start_column  (in_start_column),
    .in_first_of_text (in_first_of_text),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_desc           (q_desc)
  );

  otgs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_desc  (q_head_desc)
  );

  otgs_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head_valid            (q_head_valid),
    .head_desc             (q_head_desc),
    .pop                   (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_wire_byte         (out_wire_byte),
    .out_transaction_start (out_transaction_start),
    .out_transaction_end   (out_transaction_end),
    .out_last_of_item      (out_last_of_item)
  );

endmodule

### sv/otgs_front.sv
// ----------------------------------------------------------------------------
// OLED text glyph stream front end
// Accepts characters, tracks the running column and classifies glyphs.
// ----------------------------------------------------------------------------
`include "oled_text_glyph_stream_macros.svh"

module otgs_front
  import otgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_page_number,
  input  logic [7:0] in_start_column,
  input  logic       in_first_of_text,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_desc
);

  logic [7:0] running_column_r, running_column_nxt;
  logic [3:0] column_offset_r, column_offset_nxt;
  logic [7:0] col_base;
  logic [5:0] glyph_idx;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign col_base = in_first_of_text ? in_start_column : running_column_r;

  always_comb begin
    if (in_char_code >= CHAR_UPPER_A && in_char_code <= CHAR_UPPER_Z) begin
      glyph_idx = 6'(in_char_code - CHAR_UPPER_A) + 6'd1;
    end else if (in_char_code >= CHAR_DIGIT_0 && in_char_code <= CHAR_DIGIT_9) begin
      glyph_idx = 6'(in_char_code - CHAR_DIGIT_0) + DIGIT_GLYPH_BASE;
    end else begin
      glyph_idx = BLANK_GLYPH;
    end
  end

  always_comb begin
    q_desc.is_space  = (in_char_code == CHAR_SPACE);
    q_desc.page      = in_page_number;
    q_desc.col       = col_base + {4'd0, column_offset_r};
    q_desc.glyph_idx = glyph_idx;
  end

  assign running_column_nxt = q_push ? col_base + COL_STEP : running_column_r;
  assign column_offset_nxt  = cfg_we ? cfg_wdata : column_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_column_r <= '0;
      column_offset_r  <= COL_OFFSET_RESET;
    end else begin
      running_column_r <= running_column_nxt;
      column_offset_r  <= column_offset_nxt;
    end
  end

  `OTGS_ASSERT_NEXT(a_col_step, clk, rst_n, q_push, running_column_r == 8'($past(col_base) + COL_STEP), "running column did not advance by one cell")

endmodule

### sv/otgs_fifo.sv
// ----------------------------------------------------------------------------
// OLED text glyph stream descriptor queue
// Small register queue that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
`include "oled_text_glyph_stream_macros.svh"

module otgs_fifo
  import otgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_desc
);

  desc_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `OTGS_ASSERT_NOW(a_no_overflow, clk, rst_n, full, !push, "push into a full queue")
  `OTGS_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, head_valid, "pop from an empty queue")

endmodule

### sv/otgs_back.sv
// ----------------------------------------------------------------------------
// OLED text glyph stream back end
// Serializes each descriptor into command and data beats through an output
// register.
// ----------------------------------------------------------------------------
`include "oled_text_glyph_stream_macros.svh"

module otgs_back
  import otgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  desc_t      head_desc,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_wire_byte,
  output logic       out_transaction_start,
  output logic       out_transaction_end,
  output logic       out_last_of_item
);

  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  beat_t      beat_r;
  beat_t      beat;
  logic       adv;

  assign beat = gen_beat(head_desc, cnt_r);
  assign adv  = head_valid && (!out_valid_r || out_ready);
  assign pop  = adv && beat.last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (adv) begin
      cnt_nxt = beat.last ? '0 : cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_r <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_wire_byte         = beat_r.data;
  assign out_transaction_start = beat_r.tx_start;
  assign out_transaction_end   = beat_r.tx_end;
  assign out_last_of_item      = beat_r.last;

  `OTGS_ASSERT_NOW(a_last_ends_tx, clk, rst_n, out_valid_r && beat_r.last, beat_r.tx_end, "final beat of a character does not close its write")
  `OTGS_ASSERT_NOW(a_pop_at_end, clk, rst_n, pop, cnt_r == IDX_SPACE_LAST || cnt_r == IDX_PAD_BYTE, "descriptor retired before its stream ended")

endmodule

### bench/glyph_stream_checker.sv
// ----------------------------------------------------------------------------
// Glyph stream checker
// Watches the character and wire byte channels of the OLED text glyph stream,
// predicts the command and data bytes each accepted character must produce,
// and compares every delivered beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module glyph_stream_checker
  import otgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_page_number,
  input  logic [7:0] in_start_column,
  input  logic       in_first_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_wire_byte,
  input  logic       out_transaction_start,
  input  logic       out_transaction_end,
  input  logic       out_last_of_item,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] value;
    logic       tx_first;
    logic       tx_last;
    logic       char_done;
  } wire_beat_t;

  wire_beat_t  expected_bytes[$];
  logic [7:0]  run_col = '0;
  logic [3:0]  col_offset = COL_OFFSET_RESET;
  int          mismatches = 0;
  int          beats_seen = 0;

  function automatic logic [39:0] font_bits(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      "A": g = 40'h7E1111117E;
      "B": g = 40'h7F49494936;
      "C": g = 40'h3E41414122;
      "D": g = 40'h7F4141221C;
      "E": g = 40'h7F49494941;
      "F": g = 40'h7F09090901;
      "G": g = 40'h3E4149497A;
      "H": g = 40'h7F0808087F;
      "I": g = 40'h00417F4100;
      "J": g = 40'h2040413F01;
      "K": g = 40'h7F08142241;
      "L": g = 40'h7F40404040;
      "M": g = 40'h7F0204027F;
      "N": g = 40'h7F0408107F;
      "O": g = 40'h3E4141413E;
      "P": g = 40'h7F09090906;
      "Q": g = 40'h3E4151215E;
      "R": g = 40'h7F09192946;
      "S": g = 40'h4649494931;
      "T": g = 40'h01017F0101;
      "U": g = 40'h3F4040403F;
      "V": g = 40'h1F2040201F;
      "W": g = 40'h7F2018207F;
      "X": g = 40'h6314081463;
      "Y": g = 40'h0304780403;
      "Z": g = 40'h6151494543;
      "0": g = 40'h3E5149453E;
      "1": g = 40'h00427F4000;
      "2": g = 40'h4261514946;
      "3": g = 40'h2141454B31;
      "4": g = 40'h1814127F10;
      "5": g = 40'h2745454539;
      "6": g = 40'h3C4A494930;
      "7": g = 40'h0171090503;
      "8": g = 40'h3649494936;
      "9": g = 40'h064949291E;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

  function automatic void add_byte(input logic [7:0] value, input logic tx_first,
                                   input logic tx_last, input logic char_done);
    wire_beat_t b;
    b.value     = value;
    b.tx_first  = tx_first;
    b.tx_last   = tx_last;
    b.char_done = char_done;
    expected_bytes.push_back(b);
  endfunction

  function automatic void draw_char_bytes(input logic [7:0] code, input logic [2:0] page,
                                          input logic [7:0] start_col, input logic first);
    logic [7:0]  col;
    logic [39:0] g;
    if (first)
      run_col = start_col;
    col = run_col + {4'd0, col_offset};
    add_byte(CTRL_CMD, 1'b1, 1'b0, 1'b0);
    add_byte(PAGE_CMD_BASE + {5'd0, page}, 1'b0, 1'b1, 1'b0);
    add_byte(CTRL_CMD, 1'b1, 1'b0, 1'b0);
    add_byte({4'd0, col[3:0]}, 1'b0, 1'b1, 1'b0);
    add_byte(CTRL_CMD, 1'b1, 1'b0, 1'b0);
    add_byte(COL_HI_BASE + {4'd0, col[7:4]}, 1'b0, 1'b1, 1'b0);
    add_byte(CTRL_DATA, 1'b1, 1'b0, 1'b0);
    if (code == CHAR_SPACE) begin
      for (int i = 0; i < 6; i++)
        add_byte(8'd0, 1'b0, i == 5, i == 5);
    end else begin
      g = font_bits(code);
      for (int i = 0; i < 5; i++)
        add_byte(g[39 - 8 * i -: 8], 1'b0, i == 4, 1'b0);
      add_byte(CTRL_DATA, 1'b1, 1'b0, 1'b0);
      add_byte(8'd0, 1'b0, 1'b1, 1'b1);
    end
    run_col = run_col + COL_STEP;
  endfunction

  always @(posedge clk) begin
    wire_beat_t want;
    if (!rst_n) begin
      run_col    = '0;
      col_offset = COL_OFFSET_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_we)
        col_offset = cfg_wdata;
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: unexpected byte %02h start %b end %b last %b", beats_seen,
                     out_wire_byte, out_transaction_start, out_transaction_end,
                     out_last_of_item);
        end else begin
          want = expected_bytes.pop_front();
          if (out_wire_byte !== want.value || out_transaction_start !== want.tx_first ||
              out_transaction_end !== want.tx_last || out_last_of_item !== want.char_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected %02h start %b end %b last %b, got %02h %b %b %b",
                       beats_seen, want.value, want.tx_first, want.tx_last, want.char_done,
                       out_wire_byte, out_transaction_start, out_transaction_end,
                       out_last_of_item);
          end
        end
      end
      if (in_valid && in_ready)
        draw_char_bytes(in_char_code, in_page_number, in_start_column, in_first_of_text);
    end
    fail_count <= mismatches;
    pending    <= expected_bytes.size();
  end

endmodule

### bench/tb_oled_text_glyph_stream.sv
// ----------------------------------------------------------------------------
// OLED text glyph stream testbench
// Drives directed and random text through the glyph stream under several
// column offsets and flow-control patterns, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_oled_text_glyph_stream
  import otgs_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_code;
  logic [2:0] in_page_number;
  logic [7:0] in_start_column;
  logic       in_first_of_text;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_wire_byte;
  logic       out_transaction_start;
  logic       out_transaction_end;
  logic       out_last_of_item;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         idle_pct;
  int         stall_pct;
  logic       hold_arm;
  logic       hold_taken = 1'b0;
  int         hold_cnt = 0;
  int         cycle_count = 0;

  always #1 clk = ~clk;

  oled_text_glyph_stream dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_char_code          (in_char_code),
    .in_page_number        (in_page_number),
    .in_start_column       (in_start_column),
    .in_first_of_text      (in_first_of_text),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_wire_byte         (out_wire_byte),
    .out_transaction_start (out_transaction_start),
    .out_transaction_end   (out_transaction_end),
    .out_last_of_item      (out_last_of_item),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  glyph_stream_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_char_code          (in_char_code),
    .in_page_number        (in_page_number),
    .in_start_column       (in_start_column),
    .in_first_of_text      (in_first_of_text),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_wire_byte         (out_wire_byte),
    .out_transaction_start (out_transaction_start),
    .out_transaction_end   (out_transaction_end),
    .out_last_of_item      (out_last_of_item),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_oled_text_glyph_stream: FAIL");
      $finish;
    end
  end

  // The long hold-off lets the sender fill the block until it stalls its input.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_arm && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt   <= 400;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] code, input logic [2:0] page,
                           input logic [7:0] start_col, input logic first);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_char_code     <= code;
    in_page_number   <= page;
    in_start_column  <= start_col;
    in_first_of_text <= first;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_and_set_offset(input logic [3:0] offset);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= offset;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_text(input int count);
    int         line_left;
    int         pick;
    logic [7:0] code;
    logic [7:0] start_col;
    logic       first;
    line_left = 0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40)
        code = CHAR_UPPER_A + 8'($urandom_range(25));
      else if (pick < 60)
        code = CHAR_DIGIT_0 + 8'($urandom_range(9));
      else if (pick < 72)
        code = CHAR_SPACE;
      else
        code = 8'($urandom_range(255));
      start_col = ($urandom_range(99) < 20) ? 8'($urandom_range(255, 240))
                                            : 8'($urandom_range(255));
      if (line_left == 0) begin
        line_left = $urandom_range(20, 1);
        first     = 1'b1;
      end else begin
        first = ($urandom_range(99) < 5);
      end
      line_left--;
      send_char(code, 3'($urandom_range(7)), start_col, first);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_char_code     = '0;
    in_page_number   = '0;
    in_start_column  = '0;
    in_first_of_text = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_arm         = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_char("A", 3'd0, 8'd0, 1'b1);
    send_char("Z", 3'd7, 8'd255, 1'b0);
    send_char("0", 3'd3, 8'd0, 1'b0);
    send_char("9", 3'd4, 8'd0, 1'b0);
    send_char(CHAR_SPACE, 3'd1, 8'd0, 1'b0);
    send_char(8'h00, 3'd2, 8'd0, 1'b0);
    send_char(8'hFF, 3'd5, 8'd0, 1'b0);
    send_char("a", 3'd6, 8'd0, 1'b0);
    send_char("z", 3'd0, 8'd0, 1'b0);
    send_char(8'h80, 3'd7, 8'd0, 1'b0);
    send_char("@", 3'd1, 8'd0, 1'b0);
    send_char("[", 3'd2, 8'd0, 1'b0);
    send_char("/", 3'd3, 8'd0, 1'b0);
    send_char(":", 3'd4, 8'd0, 1'b0);
    send_char(CHAR_SPACE, 3'd7, 8'd255, 1'b1);
    send_char("M", 3'd0, 8'd0, 1'b0);
    send_char("K", 3'd6, 8'd250, 1'b1);
    send_char("5", 3'd5, 8'd17, 1'b0);
    send_char(CHAR_SPACE, 3'd2, 8'd254, 1'b1);
    send_char("Q", 3'd3, 8'd0, 1'b0);
    send_char(8'h7F, 3'd4, 8'd0, 1'b0);
    send_char(CHAR_SPACE, 3'd5, 8'd170, 1'b1);
    send_char("I", 3'd6, 8'd85, 1'b0);

    drain_and_set_offset(4'd0);
    hold_arm <= 1'b1;
    send_random_text(107);

    drain_and_set_offset(4'd15);
    idle_pct = 71;
    send_random_text(107);

    drain_and_set_offset(4'd9);
    idle_pct  = 0;
    stall_pct = 71;
    send_random_text(107);

    drain_and_set_offset(4'($urandom_range(15)));
    idle_pct  = 28;
    stall_pct = 28;
    send_random_text(107);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_oled_text_glyph_stream: PASS");
    else
      $display("tb_oled_text_glyph_stream: FAIL");
    $finish;
  end

endmodule

### oled_text_glyph_stream.f
+incdir+sv
sv/otgs_pkg.sv
sv/otgs_front.sv
sv/otgs_fifo.sv
sv/otgs_back.sv
sv/oled_text_glyph_stream.sv
bench/glyph_stream_checker.sv
bench/tb_oled_text_glyph_stream.sv
